/* rtl/core/lzwd_pkg.sv */
// lzwd_pkg: shared constants, codes and types of the lz window decompressor
`timescale 1ns / 1ps
`default_nettype none

package lzwd_pkg;

  // history window
  localparam int unsigned WINDOW_DEPTH = 4096;
  localparam int unsigned RING_AW      = $clog2(WINDOW_DEPTH);
  typedef logic [RING_AW-1:0] ring_addr_t;

  // field widths
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NEED_W  = 3;
  localparam int unsigned SIZE_W  = 24;
  localparam int unsigned DIST_W  = 12;
  localparam int unsigned RUN_W   = 9;
  localparam int unsigned LEFT_W  = 4;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_FLAG  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MATCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ADV   = 2'd3;

  // decoder phases, shared with the need codes
  localparam logic [NEED_W-1:0] PH_FLAG   = 3'd0;
  localparam logic [NEED_W-1:0] PH_MATCH  = 3'd1;
  localparam logic [NEED_W-1:0] PH_LIT    = 3'd2;
  localparam logic [NEED_W-1:0] PH_ADV    = 3'd3;
  localparam logic [NEED_W-1:0] NEED_DONE = 3'd4;
  localparam logic [NEED_W-1:0] PH_EXT    = 3'd5;

  // run length biases and flag count
  localparam logic [RUN_W-1:0]  SHORT_BIAS     = 9'd2;
  localparam logic [RUN_W-1:0]  EXT_BIAS       = 9'h12;
  localparam logic [LEFT_W-1:0] FLAGS_PER_BYTE = 4'd8;

  // configuration register indexes
  localparam logic REG_DECODED_SIZE = 1'b0;

  // item in flight between accept and the output register
  typedef struct packed {
    logic              emit;
    logic              use_ring;
    logic              fwd;
    logic              zero;
    logic [BYTE_W-1:0] lit;
    ring_addr_t        waddr;
    logic [NEED_W-1:0] need;
    logic              err;
  } stage_t;

endpackage

`default_nettype wire

/* rtl/core/lzwd_if.sv */
// lzwd_if: valid/ready channels for input items and result items
`timescale 1ns / 1ps
`default_nettype none

interface lzwd_in_if import lzwd_pkg::*;;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface lzwd_out_if import lzwd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_valid;
  logic [NEED_W-1:0] need_next;
  logic              kind_error;

  modport source (output valid, output out_byte, output out_valid, output need_next,
                  output kind_error, input ready);
  modport sink   (input valid, input out_byte, input out_valid, input need_next,
                  input kind_error, output ready);
endinterface

`default_nettype wire

/* rtl/core/lz_window_decompressor.sv */
// lz_window_decompressor: split-stream lz77 decoder with a 4096-byte history ring
//
// usage: software splits the stream and loads decoded_size over apb (offset 0)
// while the block is idle; a feeder then sends one element per item on in_i,
// choosing the kind that the last result's need_next asked for (flag byte,
// match word, literal or extension byte, advance). each item gives exactly one
// result item on out_o with the produced byte (if any), the next needed kind
// and an error bit for an item of the wrong kind, which is dropped.
// throughput: one item per cycle while out_o is not held, back to back, including
// advance runs at distance one; the single ring read port (registered read) and
// the write-back one stage later set this, with a forward path between them.
// result path: an accepted item moves through the read stage and then the output
// register, whose full flag drives out_o.valid.
// reset: control state, byte count and decoded_size clear at once; the ring
// is not swept - a fill mark makes entries never written read as zero.
// stall: when out_o is held, the output register and the read stage keep
// their items and in_i.ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module lz_window_decompressor import lzwd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  lzwd_in_if.sink          in_i,
  lzwd_out_if.source       out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // configuration
  logic [SIZE_W-1:0] decoded_size_q;

  // decoder control state
  logic [SIZE_W-1:0] bytes_out_q, bytes_out_d;
  logic [BYTE_W-1:0] flag_shift_q, flag_shift_d;
  logic [LEFT_W-1:0] flags_left_q, flags_left_d;
  logic [RUN_W-1:0]  run_left_q, run_left_d;
  ring_addr_t        run_source_q, run_source_d;
  logic [DIST_W-1:0] held_dist_q, held_dist_d;
  logic [NEED_W-1:0] phase_q, phase_d;
  logic              filled_q, filled_d;

  // read stage and output register
  stage_t            st_q, st_d;
  logic              st_valid_q;
  logic [BYTE_W-1:0] wr_byte_q;
  logic [BYTE_W-1:0] rdata_q;
  logic              out_full_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_valid_q;
  logic [NEED_W-1:0] need_q;
  logic              err_q;

  // history ring
  logic [BYTE_W-1:0] ring [WINDOW_DEPTH];

  logic              accept;
  logic              st_move;
  logic              rd_en;
  logic [BYTE_W-1:0] st_byte;
  logic [NEED_W-1:0] need_now;
  logic              kind_ok;
  logic              start_run;
  logic [RUN_W-1:0]  run_len;
  logic [DIST_W-1:0] run_dist;
  logic              use_flag;
  logic              do_emit;
  logic [BYTE_W-1:0] shift_used;
  logic [LEFT_W-1:0] left_used;

  function automatic logic [NEED_W-1:0] pick_phase(input logic [LEFT_W-1:0] left,
                                                   input logic [BYTE_W-1:0] shift);
    if (left == '0) begin
      return PH_FLAG;
    end
    return shift[BYTE_W-1] ? PH_LIT : PH_MATCH;
  endfunction

  function automatic logic [NEED_W-1:0] need_of(input logic [SIZE_W-1:0] count,
                                                input logic [SIZE_W-1:0] size,
                                                input logic [NEED_W-1:0] ph);
    if (count >= size) begin
      return NEED_DONE;
    end
    return (ph == PH_EXT) ? PH_LIT : ph;
  endfunction

  // apb register port, always ready
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DECODED_SIZE) ? {{(32-SIZE_W){1'b0}}, decoded_size_q} : '0;

  // read stage drains into the output register when that is free or taken
  assign st_move    = st_valid_q && (!out_full_q || out_o.ready);
  assign in_i.ready = !st_valid_q || st_move;
  assign accept     = in_i.valid && in_i.ready;

  assign need_now = need_of(bytes_out_q, decoded_size_q, phase_q);
  assign kind_ok  = ({1'b0, in_i.kind} == need_now);

  // flag consumed by this item
  assign shift_used = {flag_shift_q[BYTE_W-2:0], 1'b0};
  assign left_used  = flags_left_q - LEFT_W'(flags_left_q != '0);

  always_comb begin
    bytes_out_d  = bytes_out_q;
    flag_shift_d = flag_shift_q;
    flags_left_d = flags_left_q;
    run_left_d   = run_left_q;
    run_source_d = run_source_q;
    held_dist_d  = held_dist_q;
    phase_d      = phase_q;
    filled_d     = filled_q;
    start_run    = 1'b0;
    use_flag     = 1'b0;
    do_emit      = 1'b0;
    run_len      = '0;
    run_dist     = held_dist_q;
    rd_en        = 1'b0;

    st_d          = '0;
    st_d.lit      = in_i.value[BYTE_W-1:0];
    st_d.waddr    = bytes_out_q[RING_AW-1:0];
    st_d.err      = !kind_ok;
    // previous item writes this entry in the same cycle the read goes out
    st_d.fwd      = st_valid_q && st_q.emit && (st_q.waddr == run_source_q);
    st_d.zero     = !filled_q && (run_source_q >= bytes_out_q[RING_AW-1:0]);

    if (accept && kind_ok) begin
      unique case (in_i.kind)
        KIND_FLAG: begin
          flag_shift_d = in_i.value[BYTE_W-1:0];
          flags_left_d = FLAGS_PER_BYTE;
          phase_d      = pick_phase(FLAGS_PER_BYTE, in_i.value[BYTE_W-1:0]);
        end
        KIND_MATCH: begin
          held_dist_d = in_i.value[DIST_W-1:0];
          if (in_i.value[VALUE_W-1:DIST_W] == '0) begin
            phase_d = PH_EXT;
          end else begin
            start_run = 1'b1;
            run_dist  = in_i.value[DIST_W-1:0];
            run_len   = {{(RUN_W-(VALUE_W-DIST_W)){1'b0}}, in_i.value[VALUE_W-1:DIST_W]}
                        + SHORT_BIAS;
          end
        end
        KIND_BYTE: begin
          if (phase_q == PH_EXT) begin
            // extension byte of a long match
            start_run = 1'b1;
            run_len   = {1'b0, in_i.value[BYTE_W-1:0]} + EXT_BIAS;
          end else begin
            do_emit  = 1'b1;
            use_flag = 1'b1;
            phase_d  = pick_phase(left_used, shift_used);
          end
        end
        KIND_ADV: begin
          do_emit       = 1'b1;
          rd_en         = 1'b1;
          st_d.use_ring = 1'b1;
          run_source_d  = run_source_q + ring_addr_t'(1);
          run_left_d    = run_left_q - RUN_W'(run_left_q != '0);
          if (run_left_d == '0) begin
            phase_d = pick_phase(flags_left_q, flag_shift_q);
          end
        end
        default: begin
        end
      endcase
    end

    if (start_run) begin
      use_flag     = 1'b1;
      run_left_d   = run_len;
      run_source_d = bytes_out_q[RING_AW-1:0] - ring_addr_t'(run_dist) - ring_addr_t'(1);
      phase_d      = PH_ADV;
    end

    if (use_flag) begin
      flag_shift_d = shift_used;
      flags_left_d = left_used;
    end

    if (do_emit) begin
      st_d.emit   = 1'b1;
      bytes_out_d = bytes_out_q + SIZE_W'(1);
      // every entry holds a written byte once the count passes the ring end
      if (bytes_out_q[RING_AW-1:0] == '1) begin
        filled_d = 1'b1;
      end
    end

    st_d.need = need_of(bytes_out_d, decoded_size_q, phase_d);
  end

  // byte of the item in the read stage
  always_comb begin
    if (!st_q.use_ring) begin
      st_byte = st_q.lit;
    end else if (st_q.fwd) begin
      st_byte = wr_byte_q;
    end else if (st_q.zero) begin
      st_byte = '0;
    end else begin
      st_byte = rdata_q;
    end
  end

  // ring: registered read at accept, write-back when the item leaves the read stage
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= ring[run_source_q];
    end
    if (st_move && st_q.emit) begin
      ring[st_q.waddr] <= st_byte;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_q <= st_d;
    end
    if (st_move) begin
      out_byte_q  <= st_q.emit ? st_byte : '0;
      out_valid_q <= st_q.emit;
      need_q      <= st_q.need;
      err_q       <= st_q.err;
      if (st_q.emit) begin
        wr_byte_q <= st_byte;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decoded_size_q <= '0;
      bytes_out_q    <= '0;
      flag_shift_q   <= '0;
      flags_left_q   <= '0;
      run_left_q     <= '0;
      run_source_q   <= '0;
      held_dist_q    <= '0;
      phase_q        <= PH_FLAG;
      filled_q       <= 1'b0;
      st_valid_q     <= 1'b0;
      out_full_q     <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[2] == REG_DECODED_SIZE)) begin
        decoded_size_q <= pwdata[SIZE_W-1:0];
      end
      bytes_out_q  <= bytes_out_d;
      flag_shift_q <= flag_shift_d;
      flags_left_q <= flags_left_d;
      run_left_q   <= run_left_d;
      run_source_q <= run_source_d;
      held_dist_q  <= held_dist_d;
      phase_q      <= phase_d;
      filled_q     <= filled_d;
      if (accept) begin
        st_valid_q <= 1'b1;
      end else if (st_move) begin
        st_valid_q <= 1'b0;
      end
      if (st_move) begin
        out_full_q <= 1'b1;
      end else if (out_o.ready) begin
        out_full_q <= 1'b0;
      end
    end
  end

  assign out_o.valid      = out_full_q;
  assign out_o.out_byte   = out_byte_q;
  assign out_o.out_valid  = out_valid_q;
  assign out_o.need_next  = need_q;
  assign out_o.kind_error = err_q;

endmodule

`default_nettype wire
